/* src/pcbn_pkg.sv */
// pcbn_pkg: shared types and constants for the per-class box suppression block
// no dependencies
package pcbn_pkg;

  localparam int unsigned ClassW = 7;
  localparam int unsigned FieldW = 16;

  typedef struct packed {
    logic [FieldW-1:0] height;
    logic [FieldW-1:0] width;
    logic [FieldW-1:0] cy;
    logic [FieldW-1:0] cx;
  } box_t;

  typedef struct packed {
    logic [ClassW-1:0] cls;
    logic [FieldW-1:0] score;
  } key_t;

  localparam logic [0:0] CfgNumClasses = 1'b0;
  localparam logic [0:0] CfgIouThresh  = 1'b1;

endpackage

/* src/pcbn_iou.sv */
// pcbn_iou: pipelined iou overlap test between two boxes
// depends on pcbn_pkg
module pcbn_iou
  import pcbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  box_t        box_a,
  input  box_t        box_b,
  input  logic [15:0] thresh,
  output logic        hit_vld,
  output logic        hit
);

  logic signed [18:0] al, ar, at, ab, bl, br, bt, bb;
  logic signed [18:0] l_r, r_r, t_r, b_r;
  logic [15:0] aw_r, ah_r, bw_r, bh_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [19:0] dx, dy;
  logic [19:0] dx_r, dy_r;
  logic ok_r, ok2_r, ok3_r;
  logic [39:0] inter_r;
  logic [31:0] aa_r, ba_r;
  logic [31:0] aa2_r, ba2_r;
  logic [41:0] uni;
  logic [41:0] uni_r, inter2_r;
  logic [57:0] lhs_r, rhs_r;

  always_comb begin
    al = 19'(2 * $signed({box_a.cx[15], box_a.cx})) - 19'($signed({3'b0, box_a.width}));
    ar = 19'(2 * $signed({box_a.cx[15], box_a.cx})) + 19'($signed({3'b0, box_a.width}));
    at = 19'(2 * $signed({box_a.cy[15], box_a.cy})) - 19'($signed({3'b0, box_a.height}));
    ab = 19'(2 * $signed({box_a.cy[15], box_a.cy})) + 19'($signed({3'b0, box_a.height}));
    bl = 19'(2 * $signed({box_b.cx[15], box_b.cx})) - 19'($signed({3'b0, box_b.width}));
    br = 19'(2 * $signed({box_b.cx[15], box_b.cx})) + 19'($signed({3'b0, box_b.width}));
    bt = 19'(2 * $signed({box_b.cy[15], box_b.cy})) - 19'($signed({3'b0, box_b.height}));
    bb = 19'(2 * $signed({box_b.cy[15], box_b.cy})) + 19'($signed({3'b0, box_b.height}));
    dx = 20'(r_r) - 20'(l_r);
    dy = 20'(b_r) - 20'(t_r);
    uni = 42'({aa2_r, 2'b0}) + 42'({ba2_r, 2'b0}) - 42'(inter_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
    end
    l_r <= (al > bl) ? al : bl;
    r_r <= (ar < br) ? ar : br;
    t_r <= (at > bt) ? at : bt;
    b_r <= (ab < bb) ? ab : bb;
    aw_r <= box_a.width; ah_r <= box_a.height;
    bw_r <= box_b.width; bh_r <= box_b.height;
    // stage 2: extents and areas
    ok_r <= !(dx < 0 || dy < 0);
    dx_r <= dx[19:0];
    dy_r <= dy[19:0];
    aa_r <= aw_r * ah_r;
    ba_r <= bw_r * bh_r;
    // stage 3: intersection (extents are non-negative when ok)
    ok2_r <= ok_r;
    inter_r <= 40'(dx_r) * 40'(dy_r);
    aa2_r <= aa_r;
    ba2_r <= ba_r;
    // stage 4: union
    ok3_r <= ok2_r;
    inter2_r <= 42'(inter_r);
    uni_r <= uni;
    // stage 5: compare
    lhs_r <= {inter2_r[41:0], 16'b0};
    rhs_r <= 58'(thresh) * 58'(uni_r);
  end

  logic ok4_r;
  always_ff @(posedge clk) ok4_r <= ok3_r;

  assign hit_vld = v5_r;
  assign hit = ok4_r && (lhs_r > rhs_r);

endmodule

/* src/per_class_box_nms.sv */
// per_class_box_nms: load detections into memory, then greedy per-class nms
// depends on pcbn_pkg and pcbn_iou
//
//  channel | direction | handshake         | payload
//  in_     | in        | start / busy      | class, score, box, is_last
//  out_    | out       | out_valid strobe  | kept detection and flags
//  cfg_    | in        | cfg_valid / ready | index, data
//
// detections are taken while busy is low. after the last one, each kept box
// costs a scan for the best alive box, a fetch of that box, a pass through the
// five-stage iou pipeline and an emit; a closing scan and emit end the set.
// each result leaves one emit late so the final one can carry last_out. busy
// is high from the last detection on.
// reset is synchronous; stores hold garbage until written, alive marks clear.
// results cannot be stalled by the receiver.
module per_class_box_nms
  import pcbn_pkg::*;
#(
  parameter int MAX_DETECTIONS = 64,
  parameter int MAX_CLASSES    = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [6:0]        in_class_id,
  input  logic [15:0]       in_score,
  input  logic signed [15:0] in_center_x,
  input  logic signed [15:0] in_center_y,
  input  logic [15:0]       in_box_width,
  input  logic [15:0]       in_box_height,
  input  logic              in_is_last,
  output logic              out_valid,
  output logic [6:0]        out_class,
  output logic [15:0]       out_score,
  output logic signed [15:0] out_center_x,
  output logic signed [15:0] out_center_y,
  output logic [15:0]       out_width,
  output logic [15:0]       out_height,
  output logic              out_none_kept,
  output logic              out_dropped_flag,
  output logic              out_last_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int AW = $clog2(MAX_DETECTIONS);
  localparam int CW = AW + 1;
  localparam int LimW = 11;
  localparam int PipeD = 5;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_SUPP = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  box_t box_mem [MAX_DETECTIONS];
  key_t key_mem [MAX_DETECTIONS];
  logic [MAX_DETECTIONS-1:0] alive_r, alive_nxt;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic drop_r, drop_nxt;
  logic [7:0] ncls_r;
  logic [15:0] thr_r;

  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] rd_addr;
  box_t rd_box;
  key_t rd_key;
  logic rd_vld_r, rd_alive_r;
  logic [AW-1:0] rd_idx_r;

  logic found_r, found_nxt;
  logic [AW-1:0] best_r, best_nxt;
  key_t bkey_r, bkey_nxt;
  box_t bbox_r;
  logic any_out_r, any_out_nxt;

  // kept box waiting for the next emit
  key_t pend_key_r;
  box_t pend_box_r;

  // iou pipeline
  logic [AW-1:0] pidx_r [PipeD];
  logic pcand_r [PipeD];
  logic [PipeD-1:0] pvld_r;
  logic hit_vld, hit;

  logic [LimW-1:0] limit;
  logic load_ok, accept;

  assign limit = ({3'b0, ncls_r} < LimW'(MAX_CLASSES)) ? {3'b0, ncls_r} : LimW'(MAX_CLASSES);
  assign accept = start && !busy;
  assign load_ok = ({4'b0, in_class_id} < limit) && (count_r < CW'(MAX_DETECTIONS));
  assign busy = (state_r != S_LOAD);
  assign cfg_ready = !busy;
  assign rd_addr = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (accept && load_ok) begin
      box_mem[count_r[AW-1:0]] <= '{height: in_box_height, width: in_box_width,
                                    cy: in_center_y, cx: in_center_x};
      key_mem[count_r[AW-1:0]] <= '{cls: in_class_id, score: in_score};
    end
    rd_box <= box_mem[rd_addr];
    rd_key <= key_mem[rd_addr];
  end

  pcbn_iou u_iou (
    .clk(clk), .rst_n(rst_n),
    .in_vld(rd_vld_r && state_r == S_SUPP),
    .box_a(bbox_r), .box_b(rd_box), .thresh(thr_r),
    .hit_vld(hit_vld), .hit(hit)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    drop_nxt = drop_r;
    alive_nxt = alive_r;
    idx_nxt = idx_r;
    found_nxt = found_r;
    best_nxt = best_r;
    bkey_nxt = bkey_r;
    any_out_nxt = any_out_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (load_ok) begin
            count_nxt = count_r + 1'b1;
            alive_nxt[count_r[AW-1:0]] = 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_is_last) begin
            state_nxt = S_SCAN;
            idx_nxt = '0;
            found_nxt = 1'b0;
            any_out_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_r && rd_alive_r &&
            (!found_r || rd_key.cls < bkey_r.cls ||
             (rd_key.cls == bkey_r.cls && rd_key.score > bkey_r.score))) begin
          found_nxt = 1'b1;
          best_nxt = rd_idx_r;
          bkey_nxt = rd_key;
        end
        if (idx_r < count_r) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = S_PICK;
          idx_nxt = CW'(best_r);
        end
      end
      S_PICK: begin
        if (!found_r) begin
          state_nxt = S_EMIT;
        end else if (rd_vld_r) begin
          alive_nxt[best_r] = 1'b0;
          state_nxt = S_SUPP;
          idx_nxt = '0;
        end
      end
      S_SUPP: begin
        if (hit_vld && pcand_r[PipeD-1] && hit) alive_nxt[pidx_r[PipeD-1]] = 1'b0;
        if (idx_r < count_r) idx_nxt = idx_r + 1'b1;
        else if (!rd_vld_r && pvld_r == '0) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        any_out_nxt = 1'b1;
        if (found_r) begin
          state_nxt = S_SCAN;
          idx_nxt = '0;
          found_nxt = 1'b0;
        end else begin
          state_nxt = S_LOAD;
          count_nxt = '0;
          drop_nxt = 1'b0;
          alive_nxt = '0;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      drop_r <= 1'b0;
      alive_r <= '0;
      ncls_r <= 8'd80;
      thr_r <= 16'd29491;
      rd_vld_r <= 1'b0;
      found_r <= 1'b0;
      any_out_r <= 1'b0;
      pvld_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r <= drop_nxt;
      alive_r <= alive_nxt;
      found_r <= found_nxt;
      any_out_r <= any_out_nxt;
      rd_vld_r <= (state_r == S_SCAN || state_r == S_SUPP || state_r == S_PICK)
                  && idx_r < count_r && idx_r == idx_nxt - 1'b1
                  || (state_r == S_PICK && !rd_vld_r && found_r);
      pvld_r <= {pvld_r[PipeD-2:0], rd_vld_r && state_r == S_SUPP};
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CfgNumClasses: ncls_r <= cfg_data[7:0];
          CfgIouThresh:  thr_r <= cfg_data;
          default: ;
        endcase
      end
    end
    idx_r <= idx_nxt;
    best_r <= best_nxt;
    bkey_r <= bkey_nxt;
    rd_idx_r <= rd_addr;
    rd_alive_r <= alive_nxt[rd_addr];
    if (state_r == S_PICK && rd_vld_r) bbox_r <= rd_box;
    pidx_r[0] <= rd_idx_r;
    pcand_r[0] <= rd_alive_r && rd_key.cls == bkey_r.cls && rd_idx_r != best_r;
    for (int k = 1; k < PipeD; k++) begin
      pidx_r[k] <= pidx_r[k-1];
      pcand_r[k] <= pcand_r[k-1];
    end
  end

  // result register, sends the previously kept box
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= (state_r == S_EMIT) && (any_out_r || !found_r);
    out_class <= any_out_r ? pend_key_r.cls : '0;
    out_score <= any_out_r ? pend_key_r.score : '0;
    out_center_x <= any_out_r ? pend_box_r.cx : '0;
    out_center_y <= any_out_r ? pend_box_r.cy : '0;
    out_width <= any_out_r ? pend_box_r.width : '0;
    out_height <= any_out_r ? pend_box_r.height : '0;
    out_none_kept <= !any_out_r;
    out_dropped_flag <= drop_r;
    out_last_out <= !found_r;
    if (state_r == S_EMIT && found_r) begin
      pend_key_r <= bkey_r;
      pend_box_r <= bbox_r;
    end
  end

endmodule

/* sim/tb_per_class_box_nms.sv */
// tb_per_class_box_nms: directed table and random detection sets for per-class box nms
// depends on pcbn_pkg and per_class_box_nms; predicts kept boxes with its own nms model
module tb_per_class_box_nms
  import pcbn_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxDet = 64;
  localparam int MaxCls = 128;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [6:0]  cls;
    logic [15:0] score;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] w;
    logic [15:0] h;
    logic        last;
  } det_t;

  typedef struct packed {
    logic [6:0]  cls;
    logic [15:0] score;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] w;
    logic [15:0] h;
    logic        none;
    logic        drop;
    logic        last;
  } kept_t;

  typedef struct {
    det_t  d;
    logic  has_exp;
    kept_t exp_kept;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [6:0] in_class_id = '0;
  logic [15:0] in_score = '0;
  logic signed [15:0] in_center_x = '0;
  logic signed [15:0] in_center_y = '0;
  logic [15:0] in_box_width = '0;
  logic [15:0] in_box_height = '0;
  logic in_is_last = 1'b0;
  logic out_valid;
  logic [6:0] out_class;
  logic [15:0] out_score;
  logic signed [15:0] out_center_x;
  logic signed [15:0] out_center_y;
  logic [15:0] out_width;
  logic [15:0] out_height;
  logic out_none_kept;
  logic out_dropped_flag;
  logic out_last_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  per_class_box_nms dut (.*);

  always #1 clk = ~clk;

  // predictor state
  det_t held_dets[MaxDet];
  logic alive[MaxDet];
  int held_count;
  logic drop_pending;
  logic [7:0] cls_limit_reg = 8'd80;
  logic [15:0] iou_thr = 16'd29491;

  kept_t kept_q[$];
  int mismatches;
  longint cycles;
  logic no_idle;

  function automatic void add_kept(kept_t e);
    kept_q = {kept_q, e};
  endfunction

  function automatic logic iou_above(det_t a, det_t b);
    longint ax, ay, bx, by, aw, ah, bw, bh, l, r, t, bt, inter, uni;
    ax = longint'($signed(a.cx)); ay = longint'($signed(a.cy));
    bx = longint'($signed(b.cx)); by = longint'($signed(b.cy));
    aw = longint'(a.w); ah = longint'(a.h); bw = longint'(b.w); bh = longint'(b.h);
    l = (2*ax - aw > 2*bx - bw) ? 2*ax - aw : 2*bx - bw;
    r = (2*ax + aw < 2*bx + bw) ? 2*ax + aw : 2*bx + bw;
    t = (2*ay - ah > 2*by - bh) ? 2*ay - ah : 2*by - bh;
    bt = (2*ay + ah < 2*by + bh) ? 2*ay + ah : 2*by + bh;
    if (t > bt || l > r) return 1'b0;
    inter = (r - l) * (bt - t);
    uni = 4*aw*ah + 4*bw*bh - inter;
    return inter * 65536 > longint'(iou_thr) * uni;
  endfunction

  // adds the kept boxes of a finished set to kept_q, returns how many
  function automatic int predict_kept(det_t d);
    int lim, best, n, produced;
    kept_t k;
    produced = 0;
    lim = (cls_limit_reg < MaxCls) ? cls_limit_reg : MaxCls;
    if (d.cls >= lim || held_count >= MaxDet) begin
      drop_pending = 1'b1;
    end else begin
      held_dets[held_count] = d;
      alive[held_count] = 1'b1;
      held_count++;
    end
    if (!d.last) return 0;
    n = held_count;
    forever begin
      best = -1;
      for (int i = 0; i < n; i++) begin
        if (!alive[i]) continue;
        if (best < 0 || held_dets[i].cls < held_dets[best].cls ||
            (held_dets[i].cls == held_dets[best].cls &&
             held_dets[i].score > held_dets[best].score))
          best = i;
      end
      if (best < 0) break;
      alive[best] = 1'b0;
      for (int i = 0; i < n; i++)
        if (alive[i] && held_dets[i].cls == held_dets[best].cls &&
            iou_above(held_dets[best], held_dets[i]))
          alive[i] = 1'b0;
      k = '{cls: held_dets[best].cls, score: held_dets[best].score,
            cx: held_dets[best].cx, cy: held_dets[best].cy, w: held_dets[best].w,
            h: held_dets[best].h, none: 1'b0, drop: drop_pending, last: 1'b0};
      add_kept(k);
      produced++;
    end
    if (produced == 0) begin
      k = '0;
      k.none = 1'b1;
      k.drop = drop_pending;
      add_kept(k);
      produced = 1;
    end
    kept_q[kept_q.size()-1].last = 1'b1;
    for (int i = 0; i < MaxDet; i++) alive[i] = 1'b0;
    held_count = 0;
    drop_pending = 1'b0;
    return produced;
  endfunction

  always @(posedge clk) begin
    kept_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      got = '{cls: out_class, score: out_score, cx: out_center_x, cy: out_center_y,
              w: out_width, h: out_height, none: out_none_kept,
              drop: out_dropped_flag, last: out_last_out};
      if (kept_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected request result %p", got);
      end else begin
        want = kept_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic idle_maybe();
    if (!no_idle) while ($urandom_range(99) < 24) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_det(det_t d, logic has_exp, kept_t exp_kept);
    cfg_valid <= 1'b0;
    idle_maybe();
    in_class_id <= d.cls; in_score <= d.score; in_center_x <= d.cx;
    in_center_y <= d.cy; in_box_width <= d.w; in_box_height <= d.h;
    in_is_last <= d.last; start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    void'(predict_kept(d));
    if (has_exp && kept_q.size() > 0 && kept_q[kept_q.size()-1] !== exp_kept) begin
      mismatches++;
      if (mismatches <= 10) $display("predictor disagrees with table row %p", exp_kept);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    start <= 1'b0;
    while ((kept_q.size() > 0 || busy) && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgNumClasses) cls_limit_reg = val[7:0];
    else iou_thr = val;
    @(negedge clk);
  endtask

  function automatic det_t rand_det(int ncls, logic last, logic near);
    det_t d;
    d.cls = 7'($urandom_range(ncls - 1));
    d.score = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 1000) : 16'($urandom);
    if (near) begin
      d.cx = 16'($urandom_range(2400, 1600)); d.cy = 16'($urandom_range(2400, 1600));
      d.w = 16'($urandom_range(2000, 800)); d.h = 16'($urandom_range(2000, 800));
    end else begin
      d.cx = 16'($urandom); d.cy = 16'($urandom);
      d.w = 16'($urandom); d.h = 16'($urandom);
    end
    d.last = last;
    return d;
  endfunction

  row_t dir_rows[$];
  kept_t k;

  function automatic void add_row(row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  initial begin
    int set_len, ncls;
    det_t d;
    mismatches = 0; cycles = 0; no_idle = 1'b0;
    held_count = 0; drop_pending = 1'b0;
    for (int i = 0; i < MaxDet; i++) alive[i] = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty set: only item has a bad class
    k = '0; k.none = 1'b1; k.drop = 1'b1; k.last = 1'b1;
    add_row('{'{7'd127, 16'hffff, 16'h7fff, 16'h8000, 16'hffff, 16'hffff, 1'b1},
              1'b1, k});
    // single box at the extremes
    k = '{7'd0, 16'hffff, 16'h8000, 16'h7fff, 16'hffff, 16'h0000, 1'b0, 1'b0, 1'b1};
    add_row('{'{7'd0, 16'hffff, 16'h8000, 16'h7fff, 16'hffff, 16'h0000, 1'b1},
              1'b1, k});
    // overlapping pair in one class, equal scores, then other classes and an out-of-range class
    add_row('{'{7'd3, 16'd500, 16'd4096, 16'd4096, 16'd4096, 16'd4096, 1'b0},
              1'b0, '0});
    add_row('{'{7'd3, 16'd500, 16'd4200, 16'd4096, 16'd4096, 16'd4096, 1'b0},
              1'b0, '0});
    add_row('{'{7'd3, 16'd900, 16'd8000, 16'd4096, 16'd4096, 16'd4096, 1'b0},
              1'b0, '0});
    add_row('{'{7'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0});
    add_row('{'{7'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0});
    add_row('{'{7'd79, 16'd7, 16'h7fff, 16'h7fff, 16'd1, 16'd1, 1'b0}, 1'b0, '0});
    add_row('{'{7'd80, 16'd7, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1}, 1'b0, '0});
    foreach (dir_rows[i]) send_det(dir_rows[i].d, dir_rows[i].has_exp, dir_rows[i].exp_kept);
    wait_drained();

    // zero threshold and full class range; store overflow
    write_reg(CfgIouThresh, 16'd0);
    write_reg(CfgNumClasses, 16'd128);
    for (int i = 0; i < 66; i++) begin
      d = rand_det(2, i == 65, 1'b1);
      if (i == 0) d.cls = 7'd127;
      send_det(d, 1'b0, '0);
    end
    wait_drained();

    // no class in use
    write_reg(CfgNumClasses, 16'd0);
    send_det(rand_det(128, 1'b1, 1'b0), 1'b0, '0);
    wait_drained();

    // random sets over several settings
    for (int s = 0; s < 24; s++) begin
      case (s % 4)
        0: begin write_reg(CfgNumClasses, 16'd1); write_reg(CfgIouThresh, 16'hffff); end
        1: begin write_reg(CfgNumClasses, 16'd4); write_reg(CfgIouThresh, 16'($urandom)); end
        2: begin write_reg(CfgNumClasses, 16'($urandom_range(255)));
                 write_reg(CfgIouThresh, 16'd29491); end
        default: begin write_reg(CfgNumClasses, 16'd3);
                       write_reg(CfgIouThresh, 16'($urandom_range(40000, 10000))); end
      endcase
      no_idle = (s >= 10 && s < 14);
      ncls = (s % 4 == 2) ? 128 : 4;
      set_len = $urandom_range(12, 1);
      for (int i = 0; i < set_len; i++)
        send_det(rand_det(ncls, i == set_len - 1, $urandom_range(9) < 7), 1'b0, '0);
      wait_drained();
    end

    no_idle = 1'b0;
    if (mismatches == 0 && kept_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
